// ===== rtl/ppp_pkg.sv =====
// Types, constants and helper functions for the perspective point projection block.
`default_nettype none

package ppp_pkg;

   localparam int NUM_REGS = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_X_ROW_XY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_ROW_ZT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_ROW_XY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_ROW_ZT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_W_ROW_XY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_W_ROW_ZT = 3'd5;

   // 0.01 in Q32.32
   localparam logic signed [63:0] W_MIN = 64'sd42949672;

   localparam int QUOT_BITS = 40;
   localparam int REM_W = 63;
   localparam int DIVIDEND_W = 93;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUOT_BITS / STEPS_PER_STAGE;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic visible;
   } rsp_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUOT_BITS-1:0] lo;
   } div_lane_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   // one restoring step; quotient bit shifts into the low end of lo
   function automatic div_lane_type div_step(input div_lane_type x,
                                             input logic [REM_W-1:0] d);
      div_lane_type r;
      logic [REM_W:0] t;
      t = {x.rem, x.lo[QUOT_BITS-1]};
      r.lo = {x.lo[QUOT_BITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         r.lo[0] = 1'b1;
      end
      r.rem = t[REM_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/perspective_point_projection.sv =====
// Top level: pipelined world-to-screen perspective projection of Q16.16 points.
//
//   channel | ports                               | direction
//   req     | req_valid, req_ready, req           | in, one point per beat
//   rsp     | rsp_valid, rsp_ready, rsp           | out, one screen position per beat
//   csr     | csr_we, csr_index, csr_wdata        | in, coefficient writes
//
// One beat per cycle is sustained while rsp is not stalled.
// The depth is set by the 40-bit restoring divider, two quotient bits per stage.
// Synchronous reset clears the valid bits and coefficients.
// A stall at rsp freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module perspective_point_projection
   import ppp_pkg::*;
#(
   parameter int SCREEN_WIDTH = 800,
   parameter int SCREEN_HEIGHT = 600
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire req_type req,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type rsp,
   input  wire logic csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HALF_W = 29;
   localparam logic [HALF_W-1:0] HALF_X = HALF_W'(SCREEN_WIDTH * 32768);
   localparam logic [HALF_W-1:0] HALF_Y = HALF_W'(SCREEN_HEIGHT * 32768);
   localparam int PP_W = 32 + HALF_W;

   typedef struct packed {
      logic vis;
      logic [1:0] neg;
      logic [1:0] big;
      logic [REM_W-1:0] d;
      div_lane_type [1:0] lane;
   } div_stage_type;

   logic en;
   logic [CSR_DATA_W-1:0] coef_ff [NUM_REGS];

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic signed [63:0] s1_p_ff [3][4];
   logic signed [63:0] s2_a_ff [3];
   logic signed [63:0] s2_p2_ff [3];
   logic signed [63:0] s2_p3_ff [3];
   logic signed [63:0] s3_b_ff [3];
   logic signed [63:0] s3_p3_ff [3];
   logic signed [63:0] s4_c_ff [3];
   logic [63:0] s5_mag_ff [2];
   logic [1:0] s5_neg_ff;
   logic s5_vis_ff;
   logic [REM_W-1:0] s5_d_ff;
   logic [PP_W-1:0] s6_plo_ff [2];
   logic [PP_W-1:0] s6_phi_ff [2];
   logic [1:0] s6_neg_ff;
   logic s6_vis_ff;
   logic [REM_W-1:0] s6_d_ff;
   logic [DIVIDEND_W-1:0] s7_n_ff [2];
   logic [1:0] s7_neg_ff;
   logic s7_vis_ff;
   logic [REM_W-1:0] s7_d_ff;

   div_stage_type dv_ff [DIV_STAGES+1];
   div_stage_type dv_in [DIV_STAGES+1];
   logic dv_v_ff [DIV_STAGES+1];

   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) coef_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_X_ROW_XY: coef_ff[0] <= csr_wdata;
            REG_X_ROW_ZT: coef_ff[1] <= csr_wdata;
            REG_Y_ROW_XY: coef_ff[2] <= csr_wdata;
            REG_Y_ROW_ZT: coef_ff[3] <= csr_wdata;
            REG_W_ROW_XY: coef_ff[4] <= csr_wdata;
            REG_W_ROW_ZT: coef_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) dv_v_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         dv_v_ff[0] <= s7_v_ff;
         for (int i = 1; i <= DIV_STAGES; i++) dv_v_ff[i] <= dv_v_ff[i-1];
         rsp_valid_ff <= dv_v_ff[DIV_STAGES];
      end
   end

   // clip rows: products, then saturating sums
   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [31:0] kx, ky, kz, tt;
      assign kx = coef_ff[2*r][31:0];
      assign ky = coef_ff[2*r][63:32];
      assign kz = coef_ff[2*r+1][31:0];
      assign tt = coef_ff[2*r+1][63:32];

      always_ff @(posedge clock) begin
         if (en) begin
            s1_p_ff[r][0] <= req.pos_x * kx;
            s1_p_ff[r][1] <= req.pos_y * ky;
            s1_p_ff[r][2] <= req.pos_z * kz;
            s1_p_ff[r][3] <= {{16{tt[31]}}, tt, 16'b0};
            s2_a_ff[r] <= sat_add(s1_p_ff[r][0], s1_p_ff[r][1]);
            s2_p2_ff[r] <= s1_p_ff[r][2];
            s2_p3_ff[r] <= s1_p_ff[r][3];
            s3_b_ff[r] <= sat_add(s2_a_ff[r], s2_p2_ff[r]);
            s3_p3_ff[r] <= s2_p3_ff[r];
            s4_c_ff[r] <= sat_add(s3_b_ff[r], s3_p3_ff[r]);
         end
      end
   end

   // magnitude, sign, visibility; then scale by half size and form dividend
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            s5_mag_ff[a] <= s4_c_ff[a][63] ? 64'(-s4_c_ff[a]) : 64'(s4_c_ff[a]);
         end
         s5_neg_ff <= {!s4_c_ff[1][63], s4_c_ff[0][63]};
         s5_vis_ff <= !(s4_c_ff[2] < W_MIN);
         s5_d_ff <= s4_c_ff[2][REM_W-1:0];

         s6_plo_ff[0] <= s5_mag_ff[0][31:0] * HALF_X;
         s6_phi_ff[0] <= s5_mag_ff[0][63:32] * HALF_X;
         s6_plo_ff[1] <= s5_mag_ff[1][31:0] * HALF_Y;
         s6_phi_ff[1] <= s5_mag_ff[1][63:32] * HALF_Y;
         s6_neg_ff <= s5_neg_ff;
         s6_vis_ff <= s5_vis_ff;
         s6_d_ff <= s5_d_ff;

         for (int a = 0; a < 2; a++) begin
            s7_n_ff[a] <= DIVIDEND_W'(s6_plo_ff[a]) + {s6_phi_ff[a], 32'b0};
         end
         s7_neg_ff <= s6_neg_ff;
         s7_vis_ff <= s6_vis_ff;
         s7_d_ff <= s6_d_ff;
      end
   end

   // divider: seed with the bits above the cap, then two quotient bits a stage
   always_comb begin
      dv_in[0].vis = s7_vis_ff;
      dv_in[0].neg = s7_neg_ff;
      dv_in[0].d = s7_d_ff;
      for (int a = 0; a < 2; a++) begin
         dv_in[0].big[a] = REM_W'(s7_n_ff[a][DIVIDEND_W-1:QUOT_BITS]) >= s7_d_ff;
         dv_in[0].lane[a].rem = REM_W'(s7_n_ff[a][DIVIDEND_W-1:QUOT_BITS]);
         dv_in[0].lane[a].lo = s7_n_ff[a][QUOT_BITS-1:0];
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_in[k] = dv_ff[k-1];
         for (int a = 0; a < 2; a++) begin
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
               dv_in[k].lane[a] = div_step(dv_in[k].lane[a], dv_ff[k-1].d);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STAGES; k++) dv_ff[k] <= dv_in[k];
      end
   end

   // center offset and saturation
   always_comb begin
      logic [QUOT_BITS:0] q;
      logic signed [QUOT_BITS+2:0] sum;
      logic signed [31:0] res [2];
      for (int a = 0; a < 2; a++) begin
         q = dv_ff[DIV_STAGES].big[a] ? {1'b1, {QUOT_BITS{1'b0}}}
                                      : {1'b0, dv_ff[DIV_STAGES].lane[a].lo};
         if (dv_ff[DIV_STAGES].neg[a]) begin
            sum = $signed((QUOT_BITS+3)'(a == 0 ? HALF_X : HALF_Y))
                - $signed((QUOT_BITS+3)'(q));
         end else begin
            sum = $signed((QUOT_BITS+3)'(a == 0 ? HALF_X : HALF_Y))
                + $signed((QUOT_BITS+3)'(q));
         end
         if (sum > $signed((QUOT_BITS+3)'(32'h7fffffff))) begin
            res[a] = 32'h7fffffff;
         end else if (sum < -$signed((QUOT_BITS+3)'(33'h080000000))) begin
            res[a] = 32'h80000000;
         end else begin
            res[a] = sum[31:0];
         end
      end
      rsp_in.visible = dv_ff[DIV_STAGES].vis;
      rsp_in.screen_x = dv_ff[DIV_STAGES].vis ? res[0] : '0;
      rsp_in.screen_y = dv_ff[DIV_STAGES].vis ? res[1] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== verif/perspective_point_projection_tb.sv =====
// Self-checking testbench for the perspective point projection block.
`default_nettype none

module perspective_point_projection_tb;
   import ppp_pkg::*;

   localparam int SCREEN_WIDTH = 800;
   localparam int SCREEN_HEIGHT = 600;
   localparam int LATENCY = 29;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   perspective_point_projection #(
      .SCREEN_WIDTH(SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   class projection_scoreboard;
      logic [63:0] coef_regs[NUM_REGS];
      rsp_type pending_pos[$];
      int errors;
      int points;
      int visible_count;

      function void write_coef(int idx, logic [63:0] value);
         if (idx < NUM_REGS) begin
            coef_regs[idx] = value;
         end
      endfunction

      function logic signed [63:0] add_clamp(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s > 65'sh0_7fff_ffff_ffff_ffff) begin
            return 64'sh7fff_ffff_ffff_ffff;
         end
         if (s < -65'sh0_8000_0000_0000_0000) begin
            return 64'sh8000_0000_0000_0000;
         end
         return s[63:0];
      endfunction

      function logic signed [63:0] clip_row(int r, req_type p);
         logic [63:0] a;
         logic [63:0] b;
         logic signed [63:0] acc;
         a = coef_regs[2 * r];
         b = coef_regs[2 * r + 1];
         acc = 64'(p.pos_x) * 64'(signed'(a[31:0]));
         acc = add_clamp(acc, 64'(p.pos_y) * 64'(signed'(a[63:32])));
         acc = add_clamp(acc, 64'(p.pos_z) * 64'(signed'(b[31:0])));
         acc = add_clamp(acc, 64'(signed'(b[63:32])) <<< 16);
         return acc;
      endfunction

      function logic signed [31:0] axis_pos(logic signed [63:0] c, logic signed [63:0] w,
                                            logic [63:0] half, bit flip);
         bit neg;
         logic [63:0] mag;
         logic [127:0] num;
         logic [127:0] quot;
         logic signed [127:0] sum;
         neg = c[63];
         mag = neg ? -c : c;
         num = 128'(mag) * 128'(half);
         quot = num / 128'(w);
         if (quot > (128'd1 << 40)) begin
            quot = 128'd1 << 40;
         end
         if (flip) begin
            neg = !neg;
         end
         sum = neg ? signed'(128'(half)) - signed'(quot) : signed'(128'(half)) + signed'(quot);
         if (sum > 128'sd2147483647) begin
            sum = 128'sd2147483647;
         end
         if (sum < -128'sd2147483648) begin
            sum = -128'sd2147483648;
         end
         return sum[31:0];
      endfunction

      function void note_point(req_type p);
         logic signed [63:0] cx;
         logic signed [63:0] cy;
         logic signed [63:0] cw;
         rsp_type e;
         cx = clip_row(0, p);
         cy = clip_row(1, p);
         cw = clip_row(2, p);
         points++;
         if (cw < W_MIN) begin
            e = '0;
         end else begin
            e.screen_x = axis_pos(cx, cw, 64'(SCREEN_WIDTH) << 15, 1'b0);
            e.screen_y = axis_pos(cy, cw, 64'(SCREEN_HEIGHT) << 15, 1'b1);
            e.visible = 1'b1;
            visible_count++;
         end
         pending_pos.push_back(e);
      endfunction

      function void check_pos(rsp_type a);
         rsp_type e;
         if (pending_pos.size() == 0) begin
            $error("unexpected rsp beat %h", a);
            errors++;
            return;
         end
         e = pending_pos.pop_front();
         if (a.screen_x !== e.screen_x) begin
            $error("screen_x expected %0d actual %0d", e.screen_x, a.screen_x);
            errors++;
         end
         if (a.screen_y !== e.screen_y) begin
            $error("screen_y expected %0d actual %0d", e.screen_y, a.screen_y);
            errors++;
         end
         if (a.visible !== e.visible) begin
            $error("visible expected %0d actual %0d", e.visible, a.visible);
            errors++;
         end
      endfunction
   endclass

   projection_scoreboard sb;
   int idle_cycles;
   bit timed_out;
   bit rsp_stall_en;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.note_point(req);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_pos(rsp);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int g;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!rsp_stall_en) begin
            rsp_ready <= 1'b1;
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (g) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req.pos_x <= x;
      req.pos_y <= y;
      req.pos_z <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pos.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_coef(int idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.write_coef(idx, value);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return signed'($urandom_range(0, 40 << 16)) - (20 << 16);
         default: return signed'($urandom_range(0, 2000 << 16)) - (1000 << 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_coef(int mode);
      case (mode)
         0: return $urandom;
         default: return signed'($urandom_range(0, 4 << 16)) - (2 << 16);
      endcase
   endfunction

   // random camera; mode 1 puts unit weights on x in x, y in y and z in w, mode 0 is fully random
   task automatic load_camera(int mode);
      write_coef(REG_X_ROW_XY, {rand_coef(mode), mode ? 32'h0001_0000 : rand_coef(0)});
      write_coef(REG_X_ROW_ZT, {rand_coef(mode), rand_coef(mode)});
      write_coef(REG_Y_ROW_XY, {mode ? 32'h0001_0000 : rand_coef(0), rand_coef(mode)});
      write_coef(REG_Y_ROW_ZT, {rand_coef(mode), rand_coef(mode)});
      write_coef(REG_W_ROW_XY, {rand_coef(mode), rand_coef(mode)});
      write_coef(REG_W_ROW_ZT, {rand_coef(mode), mode ? 32'h0001_0000 : rand_coef(0)});
   endtask

   localparam logic [31:0] MAXP = 32'h7fff_ffff;
   localparam logic [31:0] MINN = 32'h8000_0000;

   initial begin
      int m;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_stall_en = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero coefficients: never visible
      send_point(MAXP, MINN, 32'h0, 1'b0);
      drain();

      // simple camera, then points around the w threshold and the extremes
      write_coef(REG_X_ROW_XY, {32'h0, 32'h0001_0000});
      write_coef(REG_X_ROW_ZT, {32'h0, 32'h0});
      write_coef(REG_Y_ROW_XY, {32'h0001_0000, 32'h0});
      write_coef(REG_Y_ROW_ZT, {32'h0, 32'h0});
      write_coef(REG_W_ROW_XY, {32'h0, 32'h0});
      write_coef(REG_W_ROW_ZT, {32'h0, 32'h0001_0000});
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_028f, 1'b0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_028e, 1'b0);
      send_point(32'h0001_0000, MINN, 32'h0000_0290, 1'b0);
      send_point(MAXP, MAXP, 32'h0000_0290, 1'b0);
      send_point(MINN, MINN, MAXP, 1'b0);
      send_point(MAXP, MINN, MAXP, 1'b0);
      send_point(32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_point(32'hffff_0000, 32'h0000_8000, MINN, 1'b0);
      send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      drain();

      // extreme coefficients drive the adders into saturation
      write_coef(REG_X_ROW_XY, {MAXP, MAXP});
      write_coef(REG_X_ROW_ZT, {MAXP, MAXP});
      write_coef(REG_Y_ROW_XY, {MINN, MINN});
      write_coef(REG_Y_ROW_ZT, {MINN, MINN});
      write_coef(REG_W_ROW_XY, {MAXP, MINN});
      write_coef(REG_W_ROW_ZT, {MAXP, MAXP});
      send_point(MINN, MINN, MINN, 1'b0);
      send_point(MAXP, MAXP, MAXP, 1'b0);
      send_point(MINN, MAXP, MINN, 1'b0);
      send_point(MAXP, MINN, MAXP, 1'b0);
      send_point(32'h0, 32'h0, 32'h0, 1'b0);
      drain();

      rsp_stall_en = 1'b1;
      for (int phase = 0; phase < 12 && !timed_out; phase++) begin
         m = (phase % 4 == 3) ? 0 : 1;
         load_camera(m);
         for (int i = 0; i < 120 && !timed_out; i++) begin
            send_point(rand_coord($urandom_range(0, 5) == 0 ? 0 : 1 + (phase % 2)),
                       rand_coord($urandom_range(0, 5) == 0 ? 0 : 1 + (phase % 2)),
                       rand_coord($urandom_range(0, 5) == 0 ? 0 : 1 + (phase % 2)),
                       phase != 5);
         end
         drain();
      end

      if (!timed_out) begin
         $display("covered %0d points, %0d visible, across 15 coefficient sets",
                  sb.points, sb.visible_count);
      end
      if (timed_out) begin
         $display("status: fail");
      end else if (sb.errors == 0 && sb.pending_pos.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ppp_pkg.sv
rtl/perspective_point_projection.sv
verif/perspective_point_projection_tb.sv
